>>> sv/nsr_pkg.sv
package nsr_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = DATA_W + FRAC_W;
    localparam int TOL_W     = 16;
    localparam int STEP_W    = 6;
    localparam int MAX_ITER  = 40;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_TEST,
        S_DONE
    } t_nsr_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic update;
        logic finish;
    } t_nsr_cmd;

    typedef struct packed {
        logic rad_zero;
        logic div_done;
        logic within_tol;
        logic at_cap;
        logic out_busy;
    } t_nsr_status;

endpackage

>>> sv/nsr_divider.sv
module nsr_divider
    import nsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quotient
);

    logic [DATA_W-1:0]    r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DATA_W:0]   trial;
    logic [DATA_W+1:0] diff;
    logic              q_bit;
    logic [DATA_W-1:0] n_rem;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        diff  = {1'b0, trial} - {2'b00, i_divisor};
        q_bit = ~diff[DATA_W+1];
        n_rem = q_bit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[NUM_W-2:0], q_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> sv/nsr_datapath.sv
module nsr_datapath
    import nsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tol_we,
    input  logic [TOL_W-1:0]  i_tol_wdata,
    input  logic [DATA_W-1:0] i_radicand,
    input  logic              i_out_ready,
    input  t_nsr_cmd          i_cmd,
    output t_nsr_status       o_status,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_root,
    output logic              o_converged
);

    logic [TOL_W-1:0]  r_tol;
    logic [DATA_W-1:0] r_rad;
    logic [DATA_W-1:0] r_est;
    logic [DATA_W-1:0] r_prior;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_root;
    logic              r_conv;
    logic              r_out_valid;

    logic              div_done;
    logic [NUM_W-1:0]  quotient;
    logic [NUM_W:0]    sum;
    logic [DATA_W-1:0] n_est;
    logic [DATA_W-1:0] abs_diff;
    logic [DATA_W-1:0] min_est;

    nsr_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (NUM_W'(r_rad) << FRAC_W),
        .i_divisor  (r_est),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        sum      = (NUM_W+1)'(r_est) + (NUM_W+1)'(quotient);
        n_est    = sum[DATA_W:1];
        abs_diff = (r_prior > r_est) ? (r_prior - r_est) : (r_est - r_prior);
        min_est  = (r_est < r_prior) ? r_est : r_prior;
    end

    always_comb begin
        o_status.rad_zero   = (r_rad == '0);
        o_status.div_done   = div_done;
        o_status.within_tol = (abs_diff < DATA_W'(r_tol));
        o_status.at_cap     = (r_step == STEP_W'(MAX_ITER));
        o_status.out_busy   = r_out_valid & ~i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_tol_we) begin
            r_tol <= i_tol_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rad   <= i_radicand;
            r_est   <= i_radicand;
            r_prior <= i_radicand;
            r_step  <= '0;
        end else if (i_cmd.update) begin
            r_prior <= r_est;
            r_est   <= n_est;
            r_step  <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_root <= min_est;
            r_conv <= o_status.rad_zero | o_status.within_tol;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_root      = r_root;
    assign o_converged = r_conv;

endmodule

>>> sv/nsr_ctrl.sv
module nsr_ctrl
    import nsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_nsr_status i_status,
    output logic        o_in_ready,
    output t_nsr_cmd    o_cmd
);

    t_nsr_state r_state;
    t_nsr_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.rad_zero ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                priority if (i_status.within_tol || i_status.at_cap) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.update    = 1'b0;
        o_cmd.finish    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.div_start = ~i_status.rad_zero;
            end
            S_DIV: begin
                o_cmd.update = i_status.div_done;
            end
            S_TEST: begin
                o_cmd.div_start = ~(i_status.within_tol | i_status.at_cap);
            end
            S_DONE: begin
                o_cmd.finish = ~i_status.out_busy;
            end
            default: ;
        endcase
    end

endmodule

>>> sv/newton_square_root.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_radicand
// output    out        o_out_valid / i_out_ready o_root, o_converged
// config    in         i_tol_we                  i_tol_wdata
//
// Each Newton step runs one division on the shared radix-2 divider (48 quotient bits).
// An item runs k steps, k at most 40; a zero radicand skips the divider.
// Reset is synchronous and returns the tolerance to 2 LSBs.
// A finished result waits in the output register; the next item is accepted meanwhile.
// A result that finds the output register still full waits until it is taken.
module newton_square_root
    import nsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tol_we,
    input  logic [TOL_W-1:0]  i_tol_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [DATA_W-1:0] i_radicand,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_root,
    output logic              o_converged
);

    t_nsr_cmd    cmd;
    t_nsr_status status;

    nsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    nsr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tol_we    (i_tol_we),
        .i_tol_wdata (i_tol_wdata),
        .i_radicand  (i_radicand),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_root      (o_root),
        .o_converged (o_converged)
    );

endmodule

>>> sv/nsr_checker.sv
module nsr_checker
    import nsr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic [DATA_W-1:0] i_radicand,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] o_root,
    input logic              o_converged
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_root) && $stable(o_converged))
        else $error("result changed while stalled");

    // After an input transfer the block is busy in S_CHECK and then in S_DIV or S_DONE.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("input accepted too soon after a transfer");

    // Returning to ready means the result sits in the output register.
    a_result_on_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_ready) && $past(i_rst_n) |-> o_out_valid)
        else $error("ready returned without a result");

    // When the output is free, a zero radicand passes S_CHECK and S_DONE and gives zero and converged.
    a_zero_radicand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_radicand == '0) && !o_out_valid
        |-> ##3 (o_out_valid && (o_root == '0) && o_converged))
        else $error("zero radicand result wrong");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (.*);
